### sv/wrpp_pkg.sv
// Shared types, codes and constants of the RIFF/WAVE PCM parser.
// Used by every module of the parser; depends on nothing.
`default_nettype none
package wrpp_pkg;

   localparam int FileLenWidth = 32;
   localparam int RspDataWidth = 128;

   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [15:0] FMT_PCM = 16'd1;
   localparam logic [4:0]  FMT_BODY_BYTES = 5'd16;

   localparam logic [2:0] STS_OK         = 3'd0;
   localparam logic [2:0] STS_BAD_TAGS   = 3'd1;
   localparam logic [2:0] STS_NO_FMT     = 3'd2;
   localparam logic [2:0] STS_NO_DATA    = 3'd3;
   localparam logic [2:0] STS_NOT_PCM    = 3'd4;
   localparam logic [2:0] STS_ZERO_FIELD = 3'd5;
   localparam logic [2:0] STS_MISALIGNED = 3'd6;
   localparam logic [2:0] STS_BAD_BITS   = 3'd7;

   localparam logic [1:0] SF_UNKNOWN = 2'd0;
   localparam logic [1:0] SF_U8      = 2'd1;
   localparam logic [1:0] SF_S16     = 2'd2;
   localparam logic [1:0] SF_S32     = 2'd3;

   localparam logic KIND_PCM     = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [1:0] {
      PH_TAGS,
      PH_HDR,
      PH_BODY,
      PH_STOP
   } phase_type;

   typedef enum logic [1:0] {
      CT_OTHER,
      CT_FMT,
      CT_DATA
   } chunk_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_DIVIDE,
      ST_SUMMARY
   } ctrl_state_type;

   typedef struct packed {
      logic take_item;
      logic load_data;
      logic load_sum;
      logic clear_parse;
      logic div_start;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic emit_data;
      logic div_busy;
   } dp_status_type;

endpackage
`default_nettype wire

### sv/wrpp_rem.sv
// Iterative remainder unit: one quotient bit per cycle over a 32-bit dividend.
// Depends on wrpp_pkg.
`default_nettype none
module wrpp_rem
   import wrpp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [15:0] divisor,
   output logic             busy,
   output logic [15:0]      remainder
);

   logic [5:0]  count_ff, count_in;
   logic [31:0] shift_ff, shift_in;
   logic [15:0] div_ff, div_in;
   logic [15:0] rem_ff, rem_in;
   logic [17:0] trial;

   assign trial = {1'b0, rem_ff, shift_ff[31]} - {2'b00, div_ff};

   always_comb begin
      count_in = count_ff;
      shift_in = shift_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      if (start) begin
         count_in = 6'd32;
         shift_in = dividend;
         div_in   = divisor;
         rem_in   = '0;
      end else if (count_ff != 6'd0) begin
         count_in = count_ff - 6'd1;
         shift_in = {shift_ff[30:0], 1'b0};
         if (trial[17]) begin
            rem_in = {rem_ff[14:0], shift_ff[31]};
         end else begin
            rem_in = trial[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      shift_ff <= shift_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
   end

   assign busy      = (count_ff != 6'd0);
   assign remainder = rem_ff;

endmodule
`default_nettype wire

### sv/wrpp_ctrl.sv
// Controller state machine: item handshake, summary sequencing and divider launch.
// Depends on wrpp_pkg.
`default_nettype none
module wrpp_ctrl
   import wrpp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   input  wire logic     req_eof,
   input  dp_status_type dp_status,
   output logic          req_ready,
   output ctrl_cmd_type  cmd,
   output ctrl_state_type state
);

   ctrl_state_type state_ff, state_in;
   logic           accept;

   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_eof) begin
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!dp_status.div_busy) begin
               state_in = ST_SUMMARY;
            end
         end
         ST_SUMMARY: begin
            if (dp_status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = dp_status.out_free;
            cmd.take_item = accept;
            cmd.load_data = accept && dp_status.emit_data;
         end
         ST_LAUNCH: begin
            cmd.div_start = 1'b1;
         end
         ST_DIVIDE: begin
         end
         ST_SUMMARY: begin
            cmd.load_sum    = dp_status.out_free;
            cmd.clear_parse = dp_status.out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule
`default_nettype wire

### sv/wrpp_dpath.sv
// Datapath: chunk walker registers, fmt field capture, summary checks and output register.
// Depends on wrpp_pkg and wrpp_rem.
`default_nettype none
module wrpp_dpath
   import wrpp_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_wr_en,
   input  wire logic [FileLenWidth-1:0] csr_wr_data,
   input  wire logic [7:0]              file_byte,
   input  ctrl_cmd_type                 cmd,
   output dp_status_type                dp_status,
   input  wire logic                    rsp_ready,
   output logic                         rsp_valid,
   output logic [RspDataWidth-1:0]      rsp_data,
   output logic                         rsp_kind,
   output logic                         rsp_last
);

   logic [31:0]    file_len_ff, file_len_in;
   logic [31:0]    pos_ff, pos_in;
   phase_type      phase_ff, phase_in;
   logic [31:0]    tag_ff, tag_in;
   logic [31:0]    size_ff, size_in;
   logic [32:0]    remain_ff, remain_in;
   chunk_kind_type ctype_ff, ctype_in;
   logic [4:0]     body_idx_ff, body_idx_in;
   logic           header_ok_ff, header_ok_in;
   logic           seen_fmt_ff, seen_fmt_in;
   logic           seen_data_ff, seen_data_in;
   logic [15:0]    fmt_tag_ff, fmt_tag_in;
   logic [15:0]    chan_ff, chan_in;
   logic [31:0]    rate_ff, rate_in;
   logic [15:0]    blk_ff, blk_in;
   logic [15:0]    bits_ff, bits_in;
   logic [31:0]    data_size_ff, data_size_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [125:0]   rsp_data_ff, rsp_data_in;
   logic           rsp_kind_ff, rsp_kind_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           active;
   logic           div_busy;
   logic [15:0]    remainder;
   logic [2:0]     sum_status;
   logic [1:0]     sum_format;

   assign active = (pos_ff < file_len_ff);

   wrpp_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (data_size_ff),
      .divisor   (blk_ff),
      .busy      (div_busy),
      .remainder (remainder)
   );

   always_comb begin
      logic [31:0] tag_next;
      logic [31:0] size_next;
      logic [32:0] avail;
      logic [32:0] padded;

      file_len_in  = file_len_ff;
      pos_in       = pos_ff;
      phase_in     = phase_ff;
      tag_in       = tag_ff;
      size_in      = size_ff;
      remain_in    = remain_ff;
      ctype_in     = ctype_ff;
      body_idx_in  = body_idx_ff;
      header_ok_in = header_ok_ff;
      seen_fmt_in  = seen_fmt_ff;
      seen_data_in = seen_data_ff;
      fmt_tag_in   = fmt_tag_ff;
      chan_in      = chan_ff;
      rate_in      = rate_ff;
      blk_in       = blk_ff;
      bits_in      = bits_ff;
      data_size_in = data_size_ff;

      tag_next  = {file_byte, tag_ff[31:8]};
      size_next = {file_byte, size_ff[31:8]};
      avail     = {1'b0, file_len_ff} - {1'b0, pos_ff} - 33'd1;
      padded    = {1'b0, size_next} + {32'd0, size_next[0]};

      if (csr_wr_en) begin
         file_len_in = csr_wr_data;
      end

      if (cmd.take_item && pos_ff != '1) begin
         pos_in = pos_ff + 32'd1;
      end

      if (cmd.take_item && active) begin
         case (phase_ff)
            PH_TAGS: begin
               tag_in = tag_next;
               if (pos_ff == 32'd3 && tag_next != TAG_RIFF) begin
                  header_ok_in = 1'b0;
                  phase_in     = PH_STOP;
               end else if (pos_ff == 32'd11) begin
                  if (tag_next != TAG_WAVE) begin
                     header_ok_in = 1'b0;
                     phase_in     = PH_STOP;
                  end else begin
                     phase_in  = PH_HDR;
                     remain_in = 33'd8;
                  end
               end
            end
            PH_HDR: begin
               if (remain_ff > 33'd4) begin
                  tag_in = tag_next;
               end else begin
                  size_in = size_next;
               end
               remain_in = remain_ff - 33'd1;
               if (remain_ff == 33'd1) begin
                  if ({1'b0, size_next} > avail) begin
                     phase_in = PH_STOP;
                  end else begin
                     ctype_in    = CT_OTHER;
                     body_idx_in = '0;
                     if (tag_ff == TAG_FMT && size_next >= 32'd16) begin
                        ctype_in    = CT_FMT;
                        seen_fmt_in = 1'b1;
                     end else if (tag_ff == TAG_DATA) begin
                        ctype_in     = CT_DATA;
                        seen_data_in = 1'b1;
                        data_size_in = size_next;
                     end
                     if (padded == 33'd0) begin
                        phase_in  = PH_HDR;
                        remain_in = 33'd8;
                     end else begin
                        phase_in  = PH_BODY;
                        remain_in = padded;
                     end
                  end
               end
            end
            PH_BODY: begin
               if (ctype_ff == CT_FMT && body_idx_ff < FMT_BODY_BYTES) begin
                  case (body_idx_ff[3:0])
                     4'd0:  fmt_tag_in[7:0]   = file_byte;
                     4'd1:  fmt_tag_in[15:8]  = file_byte;
                     4'd2:  chan_in[7:0]      = file_byte;
                     4'd3:  chan_in[15:8]     = file_byte;
                     4'd4:  rate_in[7:0]      = file_byte;
                     4'd5:  rate_in[15:8]     = file_byte;
                     4'd6:  rate_in[23:16]    = file_byte;
                     4'd7:  rate_in[31:24]    = file_byte;
                     4'd12: blk_in[7:0]       = file_byte;
                     4'd13: blk_in[15:8]      = file_byte;
                     4'd14: bits_in[7:0]      = file_byte;
                     4'd15: bits_in[15:8]     = file_byte;
                     default: begin
                     end
                  endcase
               end
               if (body_idx_ff < FMT_BODY_BYTES) begin
                  body_idx_in = body_idx_ff + 5'd1;
               end
               remain_in = remain_ff - 33'd1;
               if (remain_ff == 33'd1) begin
                  phase_in  = PH_HDR;
                  remain_in = 33'd8;
               end
            end
            PH_STOP: begin
            end
            default: begin
            end
         endcase
      end

      if (cmd.clear_parse) begin
         pos_in       = '0;
         phase_in     = PH_TAGS;
         tag_in       = '0;
         size_in      = '0;
         remain_in    = '0;
         ctype_in     = CT_OTHER;
         body_idx_in  = '0;
         header_ok_in = 1'b1;
         seen_fmt_in  = 1'b0;
         seen_data_in = 1'b0;
         fmt_tag_in   = '0;
         chan_in      = '0;
         rate_in      = '0;
         blk_in       = '0;
         bits_in      = '0;
         data_size_in = '0;
      end
   end

   always_comb begin
      if (!header_ok_ff || phase_ff == PH_TAGS) begin
         sum_status = STS_BAD_TAGS;
      end else if (!seen_fmt_ff) begin
         sum_status = STS_NO_FMT;
      end else if (!seen_data_ff) begin
         sum_status = STS_NO_DATA;
      end else if (fmt_tag_ff != FMT_PCM) begin
         sum_status = STS_NOT_PCM;
      end else if (rate_ff == '0 || chan_ff == '0 || blk_ff == '0 ||
                   data_size_ff == '0 || bits_ff == '0) begin
         sum_status = STS_ZERO_FIELD;
      end else if (remainder != '0) begin
         sum_status = STS_MISALIGNED;
      end else if (bits_ff != 16'd8 && bits_ff != 16'd16 && bits_ff != 16'd32) begin
         sum_status = STS_BAD_BITS;
      end else begin
         sum_status = STS_OK;
      end

      sum_format = SF_UNKNOWN;
      if (sum_status == STS_OK) begin
         if (bits_ff == 16'd8) begin
            sum_format = SF_U8;
         end else if (bits_ff == 16'd16) begin
            sum_format = SF_S16;
         end else begin
            sum_format = SF_S32;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_data) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_PCM;
         rsp_last_in  = 1'b0;
         rsp_data_in  = {117'd0, (body_idx_ff == 5'd0), file_byte};
      end else if (cmd.load_sum) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_SUMMARY;
         rsp_last_in  = 1'b1;
         rsp_data_in  = {sum_format, data_size_ff, bits_ff, blk_ff, rate_ff, chan_ff,
                         sum_status, 1'b0, 8'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         file_len_ff  <= '0;
         pos_ff       <= '0;
         phase_ff     <= PH_TAGS;
         tag_ff       <= '0;
         size_ff      <= '0;
         remain_ff    <= '0;
         ctype_ff     <= CT_OTHER;
         body_idx_ff  <= '0;
         header_ok_ff <= 1'b1;
         seen_fmt_ff  <= 1'b0;
         seen_data_ff <= 1'b0;
         fmt_tag_ff   <= '0;
         chan_ff      <= '0;
         rate_ff      <= '0;
         blk_ff       <= '0;
         bits_ff      <= '0;
         data_size_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         file_len_ff  <= file_len_in;
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         tag_ff       <= tag_in;
         size_ff      <= size_in;
         remain_ff    <= remain_in;
         ctype_ff     <= ctype_in;
         body_idx_ff  <= body_idx_in;
         header_ok_ff <= header_ok_in;
         seen_fmt_ff  <= seen_fmt_in;
         seen_data_ff <= seen_data_in;
         fmt_tag_ff   <= fmt_tag_in;
         chan_ff      <= chan_in;
         rate_ff      <= rate_in;
         blk_ff       <= blk_in;
         bits_ff      <= bits_in;
         data_size_ff <= data_size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign dp_status.out_free  = !rsp_valid_ff || rsp_ready;
   assign dp_status.emit_data = active && phase_ff == PH_BODY && ctype_ff == CT_DATA &&
                                remain_ff > {32'd0, size_ff[0]};
   assign dp_status.div_busy  = div_busy;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = {2'b00, rsp_data_ff};
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_last  = rsp_last_ff;

endmodule
`default_nettype wire

### sv/wave_riff_pcm_parser_unit.sv
// Top level of the RIFF/WAVE PCM parser: ties the controller to the datapath.
// Depends on wrpp_pkg, wrpp_ctrl and wrpp_dpath.
//
// Write the file length through csr_wr_en/csr_wr_data while the block is idle, then stream the
// file one byte per item with req_tlast on the final byte. Bytes flow at one per clock while
// the output is drained; data-chunk bytes come out as items with tuser low. The final byte
// starts a summary sequence: a launch state that starts the divider, a remainder division
// of the data size by the block alignment (one quotient bit per cycle) in the divide state,
// which waits for the divider to finish, then the summary state, which loads the summary item
// with tuser and tlast high once the output register is free. No byte is accepted before the
// summary is loaded; parse state clears with that load for the next file.
`default_nettype none
module wave_riff_pcm_parser_unit
   import wrpp_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_wr_en,
   input  wire logic [FileLenWidth-1:0] csr_wr_data,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // Fields from bit 0: file_byte[7:0].
   input  wire logic [7:0]              req_tdata,
   input  wire logic                    req_tlast,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // Fields from bit 0: pcm_byte[7:0], chunk_start[8], status[11:9], channel_count[27:12],
   // sample_rate[59:28], block_align[75:60], bits_per_sample[91:76], pcm_length[123:92],
   // sample_format[125:124], zero fill[127:126].
   output logic [RspDataWidth-1:0]      rsp_tdata,
   // Fields from bit 0: kind[0].
   output logic                         rsp_tuser,
   output logic                         rsp_tlast
);

   ctrl_cmd_type   cmd;
   dp_status_type  dp_status;
   ctrl_state_type state;

   wrpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_eof   (req_tlast),
      .dp_status (dp_status),
      .req_ready (req_tready),
      .cmd       (cmd),
      .state     (state)
   );

   wrpp_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .file_byte   (req_tdata),
      .cmd         (cmd),
      .dp_status   (dp_status),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_data    (rsp_tdata),
      .rsp_kind    (rsp_tuser),
      .rsp_last    (rsp_tlast)
   );

   a_no_accept_after_eof: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("item accepted while the summary is pending");

   a_div_only_in_divide: assert property (@(posedge clock) disable iff (reset)
      dp_status.div_busy |-> state == ST_DIVIDE)
      else $error("remainder unit busy outside the divide state");

   a_summary_after_divide: assert property (@(posedge clock) disable iff (reset)
      cmd.load_sum |-> !dp_status.div_busy && state == ST_SUMMARY)
      else $error("summary loaded before the remainder is ready");

   a_ok_has_format: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && rsp_tdata[11:9] == STS_OK |-> rsp_tdata[125:124] != SF_UNKNOWN)
      else $error("good summary without a sample format");

   a_last_is_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == KIND_SUMMARY)
      else $error("last item is not a summary");

endmodule
`default_nettype wire
